// File: src/sbba_pkg.sv
// sbba_pkg: shared types, codes, block layout tables and helper functions
// for the swizzled block bitmap allocator
// no dependencies
package sbba_pkg;

    localparam int DEF_NUM_PAGES  = 512;
    localparam int BLOCKS_PER_PAGE = 32;
    // wide enough for page numbers, spans (up to 64*128) and their sums
    localparam int CNT_W = 17;

    typedef enum logic [2:0] {
        CMD_ALLOC   = 3'd0,
        CMD_FREE    = 3'd1,
        CMD_RESERVE = 3'd2,
        CMD_QUERY   = 3'd3,
        CMD_CLEAR   = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOMEM    = 3'd1,
        ST_CONFLICT = 3'd2,
        ST_BAD      = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    localparam logic [3:0] FMT_CT32  = 4'd0;
    localparam logic [3:0] FMT_CT24  = 4'd1;
    localparam logic [3:0] FMT_T8H   = 4'd2;
    localparam logic [3:0] FMT_T4HL  = 4'd3;
    localparam logic [3:0] FMT_T4HH  = 4'd4;
    localparam logic [3:0] FMT_CT16  = 4'd5;
    localparam logic [3:0] FMT_CT16S = 4'd6;
    localparam logic [3:0] FMT_T8    = 4'd7;
    localparam logic [3:0] FMT_T4    = 4'd8;
    localparam logic [3:0] FMT_Z32   = 4'd9;
    localparam logic [3:0] FMT_Z24   = 4'd10;
    localparam logic [3:0] FMT_Z16   = 4'd11;
    localparam logic [3:0] FMT_Z16S  = 4'd12;

    typedef enum logic [2:0] {
        LAY_C32,
        LAY_C16,
        LAY_C16S,
        LAY_Z32,
        LAY_Z16,
        LAY_Z16S
    } lay_t;

    typedef enum logic [1:0] {
        OP_OR,
        OP_ANDN,
        OP_SET,
        OP_ZERO
    } sweep_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_MOD,
        S_ASCAN,
        S_AEVAL,
        S_SWEEP,
        S_QSCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [11:0] image_width;
        logic [11:0] image_height;
        logic [11:0] row_stride_pixels;
        logic [3:0]  pixel_format;
        logic        page_aligned;
        logic [13:0] free_start_block;
        logic [8:0]  first_page;
        logic [9:0]  page_count;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [13:0] block_address;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] pattern;
        logic [4:0]  max_off;
        logic [7:0]  stride_pages;
        logic [7:0]  pages_wide;
        logic [14:0] span;
    } shp_t;

    localparam logic [4:0] TAB_C32 [32] = '{
         0,  1,  4,  5, 16, 17, 20, 21,   2,  3,  6,  7, 18, 19, 22, 23,
         8,  9, 12, 13, 24, 25, 28, 29,  10, 11, 14, 15, 26, 27, 30, 31 };
    localparam logic [4:0] TAB_Z32 [32] = '{
        24, 25, 28, 29,  8,  9, 12, 13,  26, 27, 30, 31, 10, 11, 14, 15,
        16, 17, 20, 21,  0,  1,  4,  5,  18, 19, 22, 23,  2,  3,  6,  7 };
    localparam logic [4:0] TAB_C16 [32] = '{
         0,  2,  8, 10,   1,  3,  9, 11,   4,  6, 12, 14,   5,  7, 13, 15,
        16, 18, 24, 26,  17, 19, 25, 27,  20, 22, 28, 30,  21, 23, 29, 31 };
    localparam logic [4:0] TAB_C16S [32] = '{
         0,  2, 16, 18,   1,  3, 17, 19,   8, 10, 24, 26,   9, 11, 25, 27,
         4,  6, 20, 22,   5,  7, 21, 23,  12, 14, 28, 30,  13, 15, 29, 31 };
    localparam logic [4:0] TAB_Z16 [32] = '{
        24, 26, 16, 18,  25, 27, 17, 19,  28, 30, 20, 22,  29, 31, 21, 23,
         8, 10,  0,  2,   9, 11,  1,  3,  12, 14,  4,  6,  13, 15,  5,  7 };
    localparam logic [4:0] TAB_Z16S [32] = '{
        24, 26,  8, 10,  25, 27,  9, 11,  16, 18,  0,  2,  17, 19,  1,  3,
        28, 30, 12, 14,  29, 31, 13, 15,  20, 22,  4,  6,  21, 23,  5,  7 };

    function automatic logic [4:0] lay_entry(lay_t c, logic [4:0] i);
        logic [4:0] v;
        case (c)
            LAY_C32:  v = TAB_C32[i];
            LAY_C16:  v = TAB_C16[i];
            LAY_C16S: v = TAB_C16S[i];
            LAY_Z32:  v = TAB_Z32[i];
            LAY_Z16:  v = TAB_Z16[i];
            LAY_Z16S: v = TAB_Z16S[i];
            default:  v = TAB_C32[i];
        endcase
        return v;
    endfunction

    // index of the highest set bit, 0 for an empty word
    function automatic logic [4:0] high_bit(logic [31:0] w);
        logic [4:0] h;
        h = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (w[i])
                h = 5'(i);
        end
        return h;
    endfunction

endpackage

// File: src/sbba_shape.sv
// sbba_shape: derives page span and swizzled block pattern of a request
// depends on sbba_pkg (request/shape types, layout tables)
module sbba_shape
    import sbba_pkg::*;
(
    input  req_t req,
    output shp_t shp
);

    logic [2:0]  bwl, bhl, pwl, phl;
    logic [4:0]  bwm1, bhm1;
    logic [3:0]  pw, ph;
    lay_t        cls;
    logic [12:0] bx, by, sb, pgw, pgt, pgs;
    logic [3:0]  bxc, byc;
    logic [2:0]  col;
    logic [4:0]  row;
    logic [31:0] pat;
    logic [15:0] prod;

    always_comb
    begin
        case (req.pixel_format)
            FMT_CT16, FMT_CT16S, FMT_Z16, FMT_Z16S:
            begin
                bwl = 3'd4; bhl = 3'd3; pwl = 3'd2; phl = 3'd3;
            end
            FMT_T8:
            begin
                bwl = 3'd4; bhl = 3'd4; pwl = 3'd3; phl = 3'd2;
            end
            FMT_T4:
            begin
                bwl = 3'd5; bhl = 3'd4; pwl = 3'd2; phl = 3'd3;
            end
            default:
            begin
                bwl = 3'd3; bhl = 3'd3; pwl = 3'd3; phl = 3'd2;
            end
        endcase
        case (req.pixel_format)
            FMT_CT16, FMT_T4: cls = LAY_C16;
            FMT_CT16S:        cls = LAY_C16S;
            FMT_Z32, FMT_Z24: cls = LAY_Z32;
            FMT_Z16:          cls = LAY_Z16;
            FMT_Z16S:         cls = LAY_Z16S;
            default:          cls = LAY_C32;
        endcase
        bwm1 = 5'((6'd1 << bwl) - 6'd1);
        bhm1 = 5'((6'd1 << bhl) - 6'd1);
        pw   = 4'(5'd1 << pwl);
        ph   = 4'(5'd1 << phl);

        bx  = ({1'b0, req.image_width} + {8'd0, bwm1}) >> bwl;
        by  = ({1'b0, req.image_height} + {8'd0, bhm1}) >> bhl;
        sb  = ({1'b0, req.row_stride_pixels} + {8'd0, bwm1}) >> bwl;
        pgs = (sb + {9'd0, pw - 4'd1}) >> pwl;
        pgw = (bx + {9'd0, pw - 4'd1}) >> pwl;
        pgt = (by + {9'd0, ph - 4'd1}) >> phl;
        bxc = (bx > {9'd0, pw}) ? pw : bx[3:0];
        byc = (by > {9'd0, ph}) ? ph : by[3:0];

        // covered rectangle of blocks, mapped through the format layout
        pat = 32'd0;
        for (int i = 0; i < 32; i++)
        begin
            col = (pwl == 3'd3) ? 3'(i % 8) : 3'(i % 4);
            row = 5'(i) >> pwl;
            if ({1'b0, col} < bxc && {1'b0, row} < {1'b0, byc})
                pat[lay_entry(cls, 5'(i))] = 1'b1;
        end

        prod = pgs[7:0] * pgt[7:0];

        shp.valid        = (req.pixel_format <= FMT_Z16S) && (req.image_width != 12'd0)
                           && (req.image_height != 12'd0)
                           && (req.row_stride_pixels != 12'd0);
        shp.pattern      = pat;
        shp.max_off      = req.page_aligned ? 5'd0 : ~high_bit(pat);
        shp.stride_pages = pgs[7:0];
        shp.pages_wide   = pgw[7:0];
        shp.span         = prod[14:0];
    end

endmodule

// File: src/sbba_mem.sv
// sbba_mem: block map storage, one word per page, registered read
// depends on nothing but its parameter
module sbba_mem #(
    parameter int NUM_PAGES = 512
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(NUM_PAGES)-1:0] waddr,
    input  logic [31:0]                  wdata,
    input  logic                         re,
    input  logic [$clog2(NUM_PAGES)-1:0] raddr,
    output logic [31:0]                  rdata
);

    logic [31:0] mem [NUM_PAGES];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// File: src/swizzled_block_bitmap_allocator.sv
// swizzled_block_bitmap_allocator: top level, command sequencer around the map
// depends on sbba_pkg, sbba_shape, sbba_mem
//
// One transaction per command: raise start while busy is low, and exactly one
// result appears later on result for a single cycle with done high; it must be
// taken then. All work goes through the one-word-per-page map memory, and a
// sweep writes each word back while it reads the next page. After reset the
// block clears the map with busy high and gives no result. Clear sweeps the
// whole map, reserve sweeps page_count pages from first_page, and query reads
// pages from the top down until one is not empty. Free first counts pages up
// to its start page to find the start column, then sweeps its span. Allocate
// reads the used pages of the span and evaluates once for each candidate start
// page, then writes the span back at the first start page that fits.
module swizzled_block_bitmap_allocator
    import sbba_pkg::*;
#(
    parameter int NUM_PAGES = DEF_NUM_PAGES
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  req_t    req,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int AW = $clog2(NUM_PAGES);
    localparam logic [CNT_W-1:0] NP = CNT_W'(NUM_PAGES);

    state_t           state_reg, state_next;
    req_t             req_reg, req_next;
    shp_t             shp_reg, shp_next, shp_w;
    logic [CNT_W-1:0] p_reg, p_next, k_reg, k_next;
    logic [CNT_W-1:0] base_reg, base_next, count_reg, count_next;
    logic [7:0]       col_reg, col_next, str_reg, str_next, wide_reg, wide_next;
    logic [31:0]      acc_reg, acc_next, pat_reg, pat_next;
    logic             pend_reg, pend_next, report_reg, report_next;
    logic [AW-1:0]    raddr_reg, raddr_next;
    sweep_op_t        op_reg, op_next;
    status_t          status_reg, status_next;
    logic [13:0]      addr_reg, addr_next;

    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [31:0]      mem_wdata, mem_rdata;

    logic             used, scan_more, sweep_end, mod_done, alloc_last;
    logic             found, q_hit, q_empty, free_bad, res_bad, alloc_big;
    logic [7:0]       col_inc;
    logic [31:0]      off_ok;
    logic [4:0]       off_sel;
    logic [CNT_W-1:0] span, free_page, issue_addr, q_page, scan_addr;

    sbba_shape u_shape (
        .req (req),
        .shp (shp_w)
    );

    sbba_mem #(
        .NUM_PAGES (NUM_PAGES)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign span       = CNT_W'(shp_reg.span);
    assign used       = col_reg < wide_reg;
    assign col_inc    = (col_reg + 8'd1 == str_reg) ? 8'd0 : col_reg + 8'd1;
    assign scan_more  = k_reg < count_reg;
    assign sweep_end  = !scan_more && !pend_reg;
    assign mod_done   = k_reg == base_reg;
    assign alloc_last = (p_reg + CNT_W'(1) + count_reg) > NP;
    assign issue_addr = base_reg + k_reg;
    assign scan_addr  = p_reg + k_reg;
    assign free_page  = CNT_W'(req_reg.free_start_block[13:5]);
    assign free_bad   = (free_page + span) > NP;
    assign res_bad    = (CNT_W'(req_reg.first_page) + CNT_W'(req_reg.page_count)) > NP;
    assign alloc_big  = span > NP;
    assign q_hit      = pend_reg && (mem_rdata != 32'd0);
    assign q_empty    = (p_reg == '0) && !pend_reg;
    assign q_page     = CNT_W'(raddr_reg);

    // offsets where the shifted pattern misses every word of the span
    always_comb
    begin
        for (int o = 0; o < 32; o++)
            off_ok[o] = (5'(o) <= shp_reg.max_off)
                        && ((acc_reg & (shp_reg.pattern << o)) == 32'd0);
        off_sel = 5'd0;
        for (int o = 31; o >= 0; o--)
        begin
            if (off_ok[o])
                off_sel = 5'(o);
        end
    end
    assign found = |off_ok;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (start)
                    state_next = S_DISPATCH;
            S_DISPATCH:
                case (req_reg.cmd)
                    CMD_ALLOC:
                        state_next = (!shp_reg.valid || alloc_big) ? S_DONE : S_ASCAN;
                    CMD_FREE:
                        state_next = (!shp_reg.valid || free_bad) ? S_DONE : S_MOD;
                    CMD_RESERVE:
                        state_next = res_bad ? S_DONE : S_SWEEP;
                    CMD_QUERY:
                        state_next = S_QSCAN;
                    CMD_CLEAR:
                        state_next = S_SWEEP;
                    default:
                        state_next = S_DONE;
                endcase
            S_MOD:
                if (mod_done)
                    state_next = S_SWEEP;
            S_ASCAN:
                if (sweep_end)
                    state_next = S_AEVAL;
            S_AEVAL:
                if (found)
                    state_next = S_SWEEP;
                else if (alloc_last)
                    state_next = S_DONE;
                else
                    state_next = S_ASCAN;
            S_SWEEP:
                if (sweep_end)
                    state_next = report_reg ? S_DONE : S_IDLE;
            S_QSCAN:
                if (q_hit || q_empty)
                    state_next = S_DONE;
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        req_next    = req_reg;
        shp_next    = shp_reg;
        p_next      = p_reg;
        k_next      = k_reg;
        base_next   = base_reg;
        count_next  = count_reg;
        col_next    = col_reg;
        str_next    = str_reg;
        wide_next   = wide_reg;
        acc_next    = pend_reg ? (acc_reg | mem_rdata) : acc_reg;
        pat_next    = pat_reg;
        pend_next   = 1'b0;
        report_next = report_reg;
        raddr_next  = raddr_reg;
        op_next     = op_reg;
        status_next = status_reg;
        addr_next   = addr_reg;
        mem_re      = 1'b0;
        mem_raddr   = issue_addr[AW-1:0];
        mem_we      = 1'b0;
        mem_waddr   = raddr_reg;
        mem_wdata   = 32'd0;

        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    req_next = req;
                    shp_next = shp_w;
                end
            S_DISPATCH:
            begin
                status_next = ST_OK;
                addr_next   = 14'd0;
                k_next      = '0;
                col_next    = 8'd0;
                acc_next    = 32'd0;
                p_next      = '0;
                base_next   = '0;
                report_next = 1'b1;
                str_next    = shp_reg.stride_pages;
                wide_next   = shp_reg.pages_wide;
                count_next  = span;
                case (req_reg.cmd)
                    CMD_ALLOC:
                        if (!shp_reg.valid)
                            status_next = ST_BAD;
                        else if (alloc_big)
                            status_next = ST_NOMEM;
                    CMD_FREE:
                    begin
                        if (!shp_reg.valid || free_bad)
                            status_next = ST_BAD;
                        base_next = free_page;
                        pat_next  = shp_reg.pattern << req_reg.free_start_block[4:0];
                        op_next   = OP_ANDN;
                    end
                    CMD_RESERVE:
                    begin
                        if (res_bad)
                            status_next = ST_BAD;
                        base_next  = CNT_W'(req_reg.first_page);
                        count_next = CNT_W'(req_reg.page_count);
                        str_next   = 8'd1;
                        wide_next  = 8'd1;
                        op_next    = OP_SET;
                    end
                    CMD_QUERY:
                        p_next = NP;
                    CMD_CLEAR:
                    begin
                        count_next = NP;
                        str_next   = 8'd1;
                        wide_next  = 8'd1;
                        op_next    = OP_ZERO;
                    end
                    default:
                        status_next = ST_BAD;
                endcase
            end
            S_MOD:
                // free keeps the column phase of its absolute start page
                if (mod_done)
                    k_next = '0;
                else
                begin
                    k_next   = k_reg + CNT_W'(1);
                    col_next = col_inc;
                end
            S_ASCAN:
            begin
                base_next = p_reg;
                if (scan_more)
                begin
                    mem_re    = used;
                    mem_raddr = scan_addr[AW-1:0];
                    pend_next = used;
                    k_next    = k_reg + CNT_W'(1);
                    col_next  = col_inc;
                end
            end
            S_AEVAL:
            begin
                k_next   = '0;
                col_next = 8'd0;
                acc_next = 32'd0;
                if (found)
                begin
                    pat_next  = shp_reg.pattern << off_sel;
                    op_next   = OP_OR;
                    base_next = p_reg;
                    addr_next = {p_reg[8:0], off_sel};
                end
                else
                begin
                    p_next = p_reg + CNT_W'(1);
                    if (alloc_last)
                        status_next = ST_NOMEM;
                end
            end
            S_SWEEP:
            begin
                if (scan_more)
                begin
                    mem_re     = used;
                    pend_next  = used;
                    raddr_next = issue_addr[AW-1:0];
                    k_next     = k_reg + CNT_W'(1);
                    col_next   = col_inc;
                end
                // write back the word read in the previous cycle
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                    case (op_reg)
                        OP_OR:   mem_wdata = mem_rdata | pat_reg;
                        OP_ANDN:
                        begin
                            mem_wdata = mem_rdata & ~pat_reg;
                            if ((mem_rdata & pat_reg) != pat_reg)
                                status_next = ST_CONFLICT;
                        end
                        OP_SET:
                        begin
                            mem_wdata = 32'hFFFF_FFFF;
                            if (mem_rdata != 32'd0)
                                status_next = ST_CONFLICT;
                        end
                        default: mem_wdata = 32'd0;
                    endcase
                end
            end
            S_QSCAN:
                if (q_hit)
                    addr_next = {q_page[8:0], high_bit(mem_rdata)};
                else if (q_empty)
                    status_next = ST_EMPTY;
                else if (p_reg != '0)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(p_reg - CNT_W'(1));
                    raddr_next = AW'(p_reg - CNT_W'(1));
                    pend_next  = 1'b1;
                    p_next     = p_reg - CNT_W'(1);
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // start with a clearing sweep over the whole map, no result
            state_reg  <= S_SWEEP;
            k_reg      <= '0;
            base_reg   <= '0;
            count_reg  <= NP;
            col_reg    <= 8'd0;
            str_reg    <= 8'd1;
            wide_reg   <= 8'd1;
            pend_reg   <= 1'b0;
            report_reg <= 1'b0;
            op_reg     <= OP_ZERO;
            p_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            base_reg   <= base_next;
            count_reg  <= count_next;
            col_reg    <= col_next;
            str_reg    <= str_next;
            wide_reg   <= wide_next;
            pend_reg   <= pend_next;
            report_reg <= report_next;
            op_reg     <= op_next;
            p_reg      <= p_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        shp_reg    <= shp_next;
        acc_reg    <= acc_next;
        pat_reg    <= pat_next;
        raddr_reg  <= raddr_next;
        status_reg <= status_next;
        addr_reg   <= addr_next;
    end

    assign busy                 = state_reg != S_IDLE;
    assign done                 = state_reg == S_DONE;
    assign result.status        = status_reg;
    assign result.block_address = (status_reg == ST_OK) ? addr_reg : 14'd0;

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_OK || result.block_address == 14'd0))
        else $error("nonzero address with failing status");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_write_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_SWEEP && $past(mem_re)))
        else $error("map write outside a read-modify-write sweep");

endmodule
